// ===== rtl/core/sl3_pkg.sv =====
`default_nettype none

package sl3_pkg;

    // Number format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Guard register
    localparam int                GUARD_W     = 8;
    localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(1);

    // Cross terms c11..d2: difference of two full products
    localparam int CW = 2 * DATA_WIDTH + 1;

    // Wide multiplier: signed CW x CW, limbs of at most 32 bits
    localparam int MUL_LIMB  = 22;
    localparam int MUL_NL    = (CW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int MUL_MAGW  = MUL_NL * MUL_LIMB;
    localparam int MUL_ROW_W = (MUL_NL + 1) * MUL_LIMB;
    localparam int MUL_SUM_W = 2 * MUL_MAGW;
    localparam int MUL_PW    = 2 * CW;
    localparam int MUL_LAT   = 5;

    // Divider: signed numerator and denominator, saturated DATA_WIDTH quotient
    localparam int NUM3_W  = MUL_PW + 1;
    localparam int DIV_DW  = NUM3_W;
    localparam int DIV_NW  = NUM3_W + FRAC_BITS;
    localparam int DIV_SW  = DIV_DW + DATA_WIDTH;
    localparam int DIV_LAT = DATA_WIDTH + 3;

    // Input word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m_r1c1;
        logic signed [DATA_WIDTH-1:0] m_r1c2;
        logic signed [DATA_WIDTH-1:0] m_r1c3;
        logic signed [DATA_WIDTH-1:0] m_r2c1;
        logic signed [DATA_WIDTH-1:0] m_r2c2;
        logic signed [DATA_WIDTH-1:0] m_r2c3;
        logic signed [DATA_WIDTH-1:0] m_r3c1;
        logic signed [DATA_WIDTH-1:0] m_r3c2;
        logic signed [DATA_WIDTH-1:0] m_r3c3;
        logic signed [DATA_WIDTH-1:0] rhs_1;
        logic signed [DATA_WIDTH-1:0] rhs_2;
        logic signed [DATA_WIDTH-1:0] rhs_3;
    } t_in;

    // Result word
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sol_first;
        logic signed [DATA_WIDTH-1:0] sol_second;
        logic signed [DATA_WIDTH-1:0] sol_third;
        logic                         saturated;
    } t_out;

    // Values carried alongside the arithmetic units
    typedef struct packed {
        logic signed [CW-1:0]         d1;
        logic signed [CW-1:0]         c11;
        logic signed [CW-1:0]         c12;
        logic signed [DATA_WIDTH-1:0] a11;
        logic signed [DATA_WIDTH-1:0] a12;
        logic signed [DATA_WIDTH-1:0] a13;
        logic signed [DATA_WIDTH-1:0] r1;
        logic signed [DATA_WIDTH-1:0] third;
        logic signed [DATA_WIDTH-1:0] second;
        logic                         flag;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/sl3_mul.sv =====
`default_nettype none

module sl3_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic signed [sl3_pkg::CW-1:0]      i_a,
    input  logic signed [sl3_pkg::CW-1:0]      i_b,
    output logic                               o_vld,
    output logic signed [sl3_pkg::MUL_PW-1:0]  o_p
);
    import sl3_pkg::*;

    logic [MUL_MAGW-1:0]    r_am, r_bm, n_am, n_bm;
    logic [2*MUL_LIMB-1:0]  r_pp  [MUL_NL][MUL_NL];
    logic [2*MUL_LIMB-1:0]  n_pp  [MUL_NL][MUL_NL];
    logic [MUL_ROW_W-1:0]   r_row [MUL_NL];
    logic [MUL_ROW_W-1:0]   n_row [MUL_NL];
    logic [MUL_SUM_W-1:0]   r_sum, n_sum;
    logic signed [MUL_PW-1:0] r_p, n_p;
    logic [3:0]             r_neg;
    logic [4:0]             r_vld;

    // sign and magnitude
    always_comb begin
        n_am = i_a[CW-1] ? MUL_MAGW'($unsigned(-i_a)) : MUL_MAGW'($unsigned(i_a));
        n_bm = i_b[CW-1] ? MUL_MAGW'($unsigned(-i_b)) : MUL_MAGW'($unsigned(i_b));
    end

    // limb partial products
    always_comb begin
        for (int i = 0; i < MUL_NL; i++) begin
            for (int j = 0; j < MUL_NL; j++) begin
                n_pp[i][j] = r_am[i*MUL_LIMB +: MUL_LIMB] * r_bm[j*MUL_LIMB +: MUL_LIMB];
            end
        end
    end

    // one row per limb of a
    always_comb begin
        for (int i = 0; i < MUL_NL; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < MUL_NL; j++) begin
                n_row[i] = n_row[i] + (MUL_ROW_W'(r_pp[i][j]) << (j * MUL_LIMB));
            end
        end
    end

    // rows summed, then sign applied
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < MUL_NL; i++) begin
            n_sum = n_sum + (MUL_SUM_W'(r_row[i]) << (i * MUL_LIMB));
        end
        n_p = r_neg[3] ? MUL_PW'(-r_sum) : MUL_PW'(r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am  <= n_am;
            r_bm  <= n_bm;
            r_neg <= {r_neg[2:0], i_a[CW-1] ^ i_b[CW-1]};
            r_pp  <= n_pp;
            r_row <= n_row;
            r_sum <= n_sum;
            r_p   <= n_p;
        end
    end

    assign o_vld = r_vld[4];
    assign o_p   = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/sl3_div.sv =====
`default_nettype none

module sl3_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic signed [sl3_pkg::DIV_NW-1:0]      i_num,
    input  logic signed [sl3_pkg::DIV_DW-1:0]      i_den,
    output logic                                   o_vld,
    output logic signed [sl3_pkg::DATA_WIDTH-1:0]  o_quot,
    output logic                                   o_flag
);
    import sl3_pkg::*;

    // magnitude stage
    logic                 r_m_vld, r_m_neg, r_m_dz, r_m_nz;
    logic [DIV_NW-1:0]    r_m_num, n_m_num;
    logic [DIV_DW-1:0]    r_m_den, n_m_den;

    // overflow stage (index 0) and one stage per quotient bit
    logic                  r_vld [DATA_WIDTH+1];
    logic                  r_neg [DATA_WIDTH+1];
    logic                  r_dz  [DATA_WIDTH+1];
    logic                  r_nz  [DATA_WIDTH+1];
    logic                  r_ovf [DATA_WIDTH+1];
    logic [DIV_NW-1:0]     r_rem [DATA_WIDTH+1];
    logic [DIV_DW-1:0]     r_den [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_q   [DATA_WIDTH+1];
    logic [DIV_NW-1:0]     n_rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] n_q   [DATA_WIDTH+1];
    logic                  n_ovf;

    // output stage
    logic                          r_o_vld, r_flag, n_flag;
    logic signed [DATA_WIDTH-1:0]  r_quot, n_quot;
    logic [DATA_WIDTH-1:0]         w_lim, w_qm;
    logic                          w_clip;

    always_comb begin
        n_m_num = i_num[DIV_NW-1] ? DIV_NW'($unsigned(-i_num)) : DIV_NW'($unsigned(i_num));
        n_m_den = i_den[DIV_DW-1] ? DIV_DW'($unsigned(-i_den)) : DIV_DW'($unsigned(i_den));
    end

    // quotient at or above 2^DATA_WIDTH is clipped for sure
    assign n_ovf = DIV_SW'(r_m_num) >= {r_m_den, {DATA_WIDTH{1'b0}}};

    // restoring steps, most significant quotient bit first
    always_comb begin
        logic [DIV_SW-1:0] sh;
        sh       = '0;
        n_rem[0] = r_m_num;
        n_q[0]   = '0;
        for (int j = 1; j <= DATA_WIDTH; j++) begin
            sh = DIV_SW'(r_den[j-1]) << (DATA_WIDTH - j);
            if (DIV_SW'(r_rem[j-1]) >= sh) begin
                n_rem[j] = r_rem[j-1] - sh[DIV_NW-1:0];
                n_q[j]   = r_q[j-1] | (DATA_WIDTH'(1) << (DATA_WIDTH - j));
            end else begin
                n_rem[j] = r_rem[j-1];
                n_q[j]   = r_q[j-1];
            end
        end
    end

    // saturate and sign
    always_comb begin
        w_lim  = r_neg[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                   : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        w_clip = r_ovf[DATA_WIDTH] || (r_q[DATA_WIDTH] > w_lim);
        w_qm   = w_clip ? w_lim : r_q[DATA_WIDTH];
        n_flag = w_clip || r_dz[DATA_WIDTH];
        if (r_dz[DATA_WIDTH] && r_nz[DATA_WIDTH]) begin
            n_quot = '0;
        end else if (r_neg[DATA_WIDTH]) begin
            n_quot = -w_qm;
        end else begin
            n_quot = w_qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int j = 0; j <= DATA_WIDTH; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_m_vld  <= i_vld;
            r_vld[0] <= r_m_vld;
            for (int j = 1; j <= DATA_WIDTH; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_o_vld <= r_vld[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_num  <= n_m_num;
            r_m_den  <= n_m_den;
            r_m_neg  <= i_num[DIV_NW-1] ^ i_den[DIV_DW-1];
            r_m_dz   <= (i_den == '0);
            r_m_nz   <= (i_num == '0);
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_den[0] <= r_m_den;
            r_neg[0] <= r_m_neg;
            r_dz[0]  <= r_m_dz;
            r_nz[0]  <= r_m_nz;
            r_ovf[0] <= n_ovf;
            for (int j = 1; j <= DATA_WIDTH; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_dz[j]  <= r_dz[j-1];
                r_nz[j]  <= r_nz[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
            r_quot <= n_quot;
            r_flag <= n_flag;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_quot = r_quot;
    assign o_flag = r_flag;

endmodule

`default_nettype wire

// ===== rtl/core/solve_linear_3x3.sv =====
`default_nettype none

// Channel | Direction | Handshake                  | Word
// input   | in        | i_in_valid / o_in_ready    | i_in_data  (t_in)
// result  | out       | o_out_valid / i_out_ready  | o_out_data (t_out)
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (guard term)
//
// One word enters per cycle while the result word is not stalled; most of the pipeline
// depth comes from the three bit-per-stage dividers of DATA_WIDTH+3 stages each.
// Synchronous active-low reset clears all valid bits; guard term resets to 1.
// A stalled result holds the whole pipeline in place; nothing is dropped.
// Config writes are taken every cycle and used directly by the three denominator stages.
module solve_linear_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sl3_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sl3_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sl3_pkg::GUARD_W-1:0]     i_cfg_data
);
    import sl3_pkg::*;

    logic                 w_en;
    logic [GUARD_W-1:0]   r_guard;
    logic signed [DIV_DW-1:0] w_g;

    // front stages
    logic                            r_s0_vld, r_s1_vld, r_s2_vld;
    t_in                             r_s0;
    logic signed [2*DATA_WIDTH-1:0]  r_pr [12];
    logic signed [2*DATA_WIDTH-1:0]  n_pr [12];
    t_side                           r_s1_side, n_s1_side, r_s2_side, n_s2_side;
    logic signed [CW-1:0]            r_c21, r_c22, r_d2;

    // third unknown
    logic [3:0]                      w_m1_vld;
    logic signed [MUL_PW-1:0]        w_m1_p [4];
    t_side                           r_dl1 [MUL_LAT];
    logic                            r_s3_vld;
    logic signed [NUM3_W-1:0]        r_num3, r_den3;
    t_side                           r_s3_side, r_dl2 [DIV_LAT];
    logic                            w_d1_vld, w_d1_flag;
    logic signed [DATA_WIDTH-1:0]    w_d1_q;
    t_side                           w_side3;

    // second unknown
    logic                            w_m2_vld;
    logic signed [MUL_PW-1:0]        w_m2_p;
    t_side                           r_dl3 [MUL_LAT];
    logic                            r_s4_vld;
    logic signed [DIV_NW-1:0]        r_num2;
    logic signed [DIV_DW-1:0]        r_den2;
    t_side                           r_s4_side, r_dl4 [DIV_LAT];
    logic                            w_d2_vld, w_d2_flag;
    logic signed [DATA_WIDTH-1:0]    w_d2_q;
    t_side                           w_side5;

    // first unknown
    logic [1:0]                      w_m3_vld;
    logic signed [MUL_PW-1:0]        w_m3_p [2];
    t_side                           r_dl5 [MUL_LAT];
    logic                            r_s5_vld;
    logic signed [DIV_NW-1:0]        r_num1;
    logic signed [DIV_DW-1:0]        r_den1;
    t_side                           r_s5_side, r_dl6 [DIV_LAT];
    logic                            w_d3_vld, w_d3_flag;
    logic signed [DATA_WIDTH-1:0]    w_d3_q;

    // whole pipe moves unless the result word is stuck
    assign w_en        = !w_d3_vld || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign w_g         = DIV_DW'($signed({1'b0, r_guard}));

    // guard register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard <= GUARD_RESET;
        end else if (i_cfg_valid) begin
            r_guard <= i_cfg_data;
        end
    end

    // twelve 32x32 products
    always_comb begin
        n_pr[0]  = r_s0.m_r2c1 * r_s0.m_r1c2;
        n_pr[1]  = r_s0.m_r2c2 * r_s0.m_r1c1;
        n_pr[2]  = r_s0.m_r2c1 * r_s0.m_r1c3;
        n_pr[3]  = r_s0.m_r2c3 * r_s0.m_r1c1;
        n_pr[4]  = r_s0.m_r3c1 * r_s0.m_r2c2;
        n_pr[5]  = r_s0.m_r3c2 * r_s0.m_r2c1;
        n_pr[6]  = r_s0.m_r3c1 * r_s0.m_r2c3;
        n_pr[7]  = r_s0.m_r3c3 * r_s0.m_r2c1;
        n_pr[8]  = r_s0.rhs_1 * r_s0.m_r2c1;
        n_pr[9]  = r_s0.rhs_2 * r_s0.m_r1c1;
        n_pr[10] = r_s0.rhs_2 * r_s0.m_r3c1;
        n_pr[11] = r_s0.rhs_3 * r_s0.m_r2c1;
        n_s1_side     = '0;
        n_s1_side.a11 = r_s0.m_r1c1;
        n_s1_side.a12 = r_s0.m_r1c2;
        n_s1_side.a13 = r_s0.m_r1c3;
        n_s1_side.r1  = r_s0.rhs_1;
    end

    // cross terms
    always_comb begin
        n_s2_side     = r_s1_side;
        n_s2_side.c11 = CW'(r_pr[0]) - CW'(r_pr[1]);
        n_s2_side.c12 = CW'(r_pr[2]) - CW'(r_pr[3]);
        n_s2_side.d1  = CW'(r_pr[8]) - CW'(r_pr[9]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0      <= i_in_data;
            r_pr      <= n_pr;
            r_s1_side <= n_s1_side;
            r_s2_side <= n_s2_side;
            r_c21     <= CW'(r_pr[4]) - CW'(r_pr[5]);
            r_c22     <= CW'(r_pr[6]) - CW'(r_pr[7]);
            r_d2      <= CW'(r_pr[10]) - CW'(r_pr[11]);
        end
    end

    // third: numerator d1*c21 - d2*c11, denominator c12*c21 - c22*c11 + g
    sl3_mul u_m1_a (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s2_vld),
                    .i_a(r_s2_side.d1), .i_b(r_c21), .o_vld(w_m1_vld[0]), .o_p(w_m1_p[0]));
    sl3_mul u_m1_b (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s2_vld),
                    .i_a(r_d2), .i_b(r_s2_side.c11), .o_vld(w_m1_vld[1]), .o_p(w_m1_p[1]));
    sl3_mul u_m1_c (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s2_vld),
                    .i_a(r_s2_side.c12), .i_b(r_c21), .o_vld(w_m1_vld[2]), .o_p(w_m1_p[2]));
    sl3_mul u_m1_d (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s2_vld),
                    .i_a(r_c22), .i_b(r_s2_side.c11), .o_vld(w_m1_vld[3]), .o_p(w_m1_p[3]));

    sl3_div u_d1 (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s3_vld),
                  .i_num({r_num3, {FRAC_BITS{1'b0}}}), .i_den(r_den3),
                  .o_vld(w_d1_vld), .o_quot(w_d1_q), .o_flag(w_d1_flag));

    always_comb begin
        w_side3       = r_dl2[DIV_LAT-1];
        w_side3.third = w_d1_q;
        w_side3.flag  = w_d1_flag;
    end

    // second: (d1 << F - c12*third) / (c11 + g)
    sl3_mul u_m2 (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_d1_vld),
                  .i_a(w_side3.c12), .i_b(CW'(w_d1_q)), .o_vld(w_m2_vld), .o_p(w_m2_p));

    sl3_div u_d2 (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s4_vld),
                  .i_num(r_num2), .i_den(r_den2),
                  .o_vld(w_d2_vld), .o_quot(w_d2_q), .o_flag(w_d2_flag));

    always_comb begin
        w_side5        = r_dl4[DIV_LAT-1];
        w_side5.second = w_d2_q;
        w_side5.flag   = r_dl4[DIV_LAT-1].flag | w_d2_flag;
    end

    // first: (r1 << F - a13*third - a12*second) / (a11 + g)
    sl3_mul u_m3_a (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_d2_vld),
                    .i_a(CW'(w_side5.a13)), .i_b(CW'(w_side5.third)),
                    .o_vld(w_m3_vld[0]), .o_p(w_m3_p[0]));
    sl3_mul u_m3_b (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_d2_vld),
                    .i_a(CW'(w_side5.a12)), .i_b(CW'(w_d2_q)),
                    .o_vld(w_m3_vld[1]), .o_p(w_m3_p[1]));

    sl3_div u_d3 (.i_clk, .i_rst_n, .i_en(w_en), .i_vld(r_s5_vld),
                  .i_num(r_num1), .i_den(r_den1),
                  .o_vld(w_d3_vld), .o_quot(w_d3_q), .o_flag(w_d3_flag));

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= &w_m1_vld;
            r_s4_vld <= w_m2_vld;
            r_s5_vld <= &w_m3_vld;
        end
    end

    // numerators, denominators and side delay lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num3    <= NUM3_W'(w_m1_p[0]) - NUM3_W'(w_m1_p[1]);
            r_den3    <= NUM3_W'(w_m1_p[2]) - NUM3_W'(w_m1_p[3]) + w_g;
            r_s3_side <= r_dl1[MUL_LAT-1];
            r_num2    <= (DIV_NW'(r_dl3[MUL_LAT-1].d1) <<< FRAC_BITS) - DIV_NW'(w_m2_p);
            r_den2    <= DIV_DW'(r_dl3[MUL_LAT-1].c11) + w_g;
            r_s4_side <= r_dl3[MUL_LAT-1];
            r_num1    <= (DIV_NW'(r_dl5[MUL_LAT-1].r1) <<< FRAC_BITS)
                         - DIV_NW'(w_m3_p[0]) - DIV_NW'(w_m3_p[1]);
            r_den1    <= DIV_DW'(r_dl5[MUL_LAT-1].a11) + w_g;
            r_s5_side <= r_dl5[MUL_LAT-1];

            r_dl1[0] <= r_s2_side;
            r_dl3[0] <= w_side3;
            r_dl5[0] <= w_side5;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl1[i] <= r_dl1[i-1];
                r_dl3[i] <= r_dl3[i-1];
                r_dl5[i] <= r_dl5[i-1];
            end
            r_dl2[0] <= r_s3_side;
            r_dl4[0] <= r_s4_side;
            r_dl6[0] <= r_s5_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl2[i] <= r_dl2[i-1];
                r_dl4[i] <= r_dl4[i-1];
                r_dl6[i] <= r_dl6[i-1];
            end
        end
    end

    // result word
    always_comb begin
        o_out_data.sol_first  = w_d3_q;
        o_out_data.sol_second = r_dl6[DIV_LAT-1].second;
        o_out_data.sol_third  = r_dl6[DIV_LAT-1].third;
        o_out_data.saturated  = r_dl6[DIV_LAT-1].flag | w_d3_flag;
    end
    assign o_out_valid = w_d3_vld;

`ifndef SYNTHESIS
    // a held result word must back-pressure the input side
    a_stall_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // while stalled the result word must not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(o_in_ready) |-> $stable(o_out_data) && o_out_valid)
        else $error("result changed during stall");

    // guard term comes out of reset at its default
    a_guard_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> r_guard == GUARD_RESET)
        else $error("guard term not at reset value");

    // parallel multiplier lanes stay in step
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m1_vld == '0 || w_m1_vld == '1) && (w_m3_vld == '0 || w_m3_vld == '1))
        else $error("multiplier lanes out of step");
`endif

endmodule

`default_nettype wire

// ===== tb/solve_linear_3x3_tb.sv =====
`default_nettype none

module solve_linear_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sl3_pkg::*;

    // Wide signed arithmetic for the golden solver; every intermediate fits comfortably
    typedef logic signed [299:0] wide_t;

    localparam int PIPE_LAT   = 126;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_ITEMS = 190;

    localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(1) <<< FRAC_BITS;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  in_word = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [GUARD_W-1:0]   cfg_word = '0;

    // Scoreboard and stimulus state
    t_in                  pending_words[$];
    t_out                 expected_solutions[$];
    logic [GUARD_W-1:0]   guard_shadow = GUARD_RESET;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 recv_hold = 1'b0;
    int                   mismatches = 0;
    int                   words_sent = 0;
    int                   words_checked = 0;
    int                   sat_seen = 0;

    solve_linear_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_word)
    );

    always #5 i_clk = ~i_clk;

    // Saturating truncating divide, flags clipping and zero denominators
    function automatic logic signed [DATA_WIDTH-1:0] div_clip(
        input wide_t num, input wide_t den, inout logic flag);
        wide_t q;
        if (den == 0) begin
            flag = 1'b1;
            if (num > 0) return Q_MAX;
            if (num < 0) return Q_MIN;
            return '0;
        end
        q = num / den;
        if (q > wide_t'(Q_MAX)) begin
            flag = 1'b1;
            return Q_MAX;
        end
        if (q < wide_t'(Q_MIN)) begin
            flag = 1'b1;
            return Q_MIN;
        end
        return q[DATA_WIDTH-1:0];
    endfunction

    // Golden elimination solver
    function automatic t_out solve_system(input t_in w, input logic [GUARD_W-1:0] guard);
        wide_t a11, a12, a13, a21, a22, a23, a31, a32, a33, r1, r2, r3, g;
        wide_t c11, c12, c21, c22, d1, d2, num, den, th, se;
        logic  flag;
        t_out  res;
        a11 = w.m_r1c1; a12 = w.m_r1c2; a13 = w.m_r1c3;
        a21 = w.m_r2c1; a22 = w.m_r2c2; a23 = w.m_r2c3;
        a31 = w.m_r3c1; a32 = w.m_r3c2; a33 = w.m_r3c3;
        r1 = w.rhs_1; r2 = w.rhs_2; r3 = w.rhs_3;
        g = {292'd0, guard};
        flag = 1'b0;
        c11 = a21 * a12 - a22 * a11;
        c12 = a21 * a13 - a23 * a11;
        c21 = a31 * a22 - a32 * a21;
        c22 = a31 * a23 - a33 * a21;
        d1  = r1 * a21 - r2 * a11;
        d2  = r2 * a31 - r3 * a21;
        num = (d1 * c21 - d2 * c11) <<< FRAC_BITS;
        den = c12 * c21 - c22 * c11 + g;
        res.sol_third = div_clip(num, den, flag);
        th = res.sol_third;
        num = (d1 <<< FRAC_BITS) - c12 * th;
        res.sol_second = div_clip(num, c11 + g, flag);
        se = res.sol_second;
        num = (r1 <<< FRAC_BITS) - a13 * th - a12 * se;
        res.sol_first = div_clip(num, a11 + g, flag);
        res.saturated = flag;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Driver: offers the head of the pending queue, holds it until taken
    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = in_valid;
        if (in_valid && o_in_ready) begin
            expected_solutions.push_back(solve_system(in_word, guard_shadow));
            void'(pending_words.pop_front());
            words_sent++;
            next_valid = 1'b0;
        end
        if (!next_valid && i_rst_n && pending_words.size() != 0 &&
            $urandom_range(99, 0) >= send_idle_pct) begin
            next_valid = 1'b1;
            in_word <= pending_words[0];
        end
        in_valid <= next_valid;
    end

    // Monitor: checks each taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_w;
        if (o_out_valid && out_ready) begin
            if (expected_solutions.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                exp_w = expected_solutions.pop_front();
                words_checked++;
                if (exp_w.saturated) sat_seen++;
                if (o_out_data.sol_first !== exp_w.sol_first)
                    report_mismatch($sformatf("sol_first got %h want %h",
                        o_out_data.sol_first, exp_w.sol_first));
                if (o_out_data.sol_second !== exp_w.sol_second)
                    report_mismatch($sformatf("sol_second got %h want %h",
                        o_out_data.sol_second, exp_w.sol_second));
                if (o_out_data.sol_third !== exp_w.sol_third)
                    report_mismatch($sformatf("sol_third got %h want %h",
                        o_out_data.sol_third, exp_w.sol_third));
                if (o_out_data.saturated !== exp_w.saturated)
                    report_mismatch($sformatf("saturated got %b want %b",
                        o_out_data.saturated, exp_w.saturated));
            end
        end
        out_ready <= i_rst_n && !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    function automatic logic signed [DATA_WIDTH-1:0] pick_value(input int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000;
            2: begin
                case ($urandom_range(5, 0))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return 1;
                    4: return -1;
                    default: return Q_ONE;
                endcase
            end
            default: return $signed($urandom_range(32'h0000_1000, 0)) - 32'sh0000_0800;
        endcase
    endfunction

    // Random system: mostly small, some diagonally weighted; some raw and extreme noise
    function automatic t_in random_system();
        t_in w;
        int  mode, k;
        mode = $urandom_range(9, 0);
        k = (mode < 6) ? 1 : (mode < 8) ? 0 : (mode == 8) ? 2 : 3;
        w.m_r1c1 = pick_value(k); w.m_r1c2 = pick_value(k); w.m_r1c3 = pick_value(k);
        w.m_r2c1 = pick_value(k); w.m_r2c2 = pick_value(k); w.m_r2c3 = pick_value(k);
        w.m_r3c1 = pick_value(k); w.m_r3c2 = pick_value(k); w.m_r3c3 = pick_value(k);
        w.rhs_1 = pick_value(k); w.rhs_2 = pick_value(k); w.rhs_3 = pick_value(k);
        if (mode < 4) begin
            w.m_r1c1 += 32'sh0008_0000;
            w.m_r2c2 += 32'sh0008_0000;
            w.m_r3c3 -= 32'sh0008_0000;
        end
        return w;
    endfunction

    function automatic t_in uniform_system(input logic signed [DATA_WIDTH-1:0] v,
                                           input logic signed [DATA_WIDTH-1:0] r);
        t_in w;
        w = '{default: v};
        w.rhs_1 = r; w.rhs_2 = r; w.rhs_3 = r;
        return w;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_solutions.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_guard(input logic [GUARD_W-1:0] g);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_word  <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        guard_shadow = g;
    endtask

    task automatic load_directed();
        t_in w;
        // all-zero system: every denominator is the guard
        pending_words.push_back('0);
        // identity with distinct right-hand side
        w = '0;
        w.m_r1c1 = Q_ONE; w.m_r2c2 = Q_ONE; w.m_r3c3 = Q_ONE;
        w.rhs_1 = 32'sh0003_0000; w.rhs_2 = -32'sh0002_8000; w.rhs_3 = 32'sh0000_4000;
        pending_words.push_back(w);
        // field extremes
        pending_words.push_back(uniform_system(Q_MAX, Q_MAX));
        pending_words.push_back(uniform_system(Q_MIN, Q_MIN));
        pending_words.push_back(uniform_system(Q_MAX, Q_MIN));
        pending_words.push_back(uniform_system(Q_MIN, Q_MAX));
        pending_words.push_back(uniform_system(-1, 1));
        pending_words.push_back(uniform_system(1, -1));
        // singular matrix, nonzero rhs of both signs: third and second denominators reduce to the guard
        pending_words.push_back(uniform_system(Q_ONE, Q_ONE));
        pending_words.push_back(uniform_system(Q_ONE, -Q_ONE));
        // tiny diagonal, huge rhs: clipped quotients
        w = '0;
        w.m_r1c1 = 1; w.m_r2c2 = 1; w.m_r3c3 = 1;
        w.rhs_1 = Q_MAX; w.rhs_2 = Q_MIN; w.rhs_3 = Q_MAX;
        pending_words.push_back(w);
        // alternating extremes across the matrix
        w = '{default: Q_MIN};
        w.m_r1c2 = Q_MAX; w.m_r2c1 = Q_MAX; w.m_r3c3 = Q_MAX; w.rhs_2 = 0;
        pending_words.push_back(w);
        for (int i = 0; i < 8; i++) pending_words.push_back(random_system());
    endtask

    task automatic load_random(input int n);
        for (int i = 0; i < n; i++) pending_words.push_back(random_system());
    endtask

    // Timeout
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Sequencer
    initial begin
        logic [GUARD_W-1:0] g;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset guard value, sender lightly idle, receiver heavily idle
        send_idle_pct = 12; recv_idle_pct = 68;
        load_directed();
        load_random(PHASE_ITEMS - 20);
        wait_idle();

        // zero guard, roles of idling swapped
        write_guard('0);
        send_idle_pct = 68; recv_idle_pct = 12;
        load_directed();
        load_random(PHASE_ITEMS - 20);
        wait_idle();

        // largest guard, no idling at all
        write_guard('1);
        send_idle_pct = 0; recv_idle_pct = 0;
        load_directed();
        load_random(PHASE_ITEMS - 20);
        wait_idle();

        // random guard, receiver stops for a long stretch so the pipeline backs up
        g = $urandom_range(254, 2);
        write_guard(g);
        send_idle_pct = 0; recv_idle_pct = 0;
        load_random(PHASE_ITEMS);
        repeat (20) @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        recv_hold <= 1'b0;
        wait_idle();

        // back to a guard of one, mixed idling
        write_guard(GUARD_W'(1));
        send_idle_pct = 12; recv_idle_pct = 68;
        load_random(PHASE_ITEMS / 2);
        wait_idle();
        send_idle_pct = 68; recv_idle_pct = 12;
        load_random(PHASE_ITEMS / 2);
        wait_idle();

        $display("Solved %0d systems over five guard settings (0, 1, 255, random, 1),",
                 words_checked);
        $display("%0d of them saturated; %0d words sent, long receiver stall included.",
                 sat_seen, words_sent);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
